[rtl/sfsb_pkg.sv]
// shared types and constants of the spindle follow step batcher
// used by sfsb_ctrl, sfsb_dpath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfsb_pkg;

  localparam int ACC_FRAC_BITS_DEF = 24;
  localparam int MIN_SAMPLE_US     = 500;

  // steps/s in q.8: 1e6 us per second times 256
  localparam int SPEED_SCALE = 256000000;

  localparam logic [31:0] GEAR_RATIO_RESET = 32'd16777216;
  localparam logic [15:0] MAX_BATCH_RESET  = 16'd1024;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH_STEPS = 2'd1;

  localparam int ACTION_W = 1;
  localparam logic [ACTION_W-1:0] ACT_BATCH  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_RESYNC = 1'b1;

  // quotient bits of the speed division (numerator width)
  localparam int DIV_STEPS = 61;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_POS,
    ST_ERR,
    ST_BATCH,
    ST_CMD,
    ST_RESYNC,
    ST_SMUL,
    ST_DINIT,
    ST_DIV,
    ST_SAT,
    ST_DIFF,
    ST_FSTEP,
    ST_FILT,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_POS,
    OP_ERR,
    OP_BATCH,
    OP_CMD,
    OP_RESYNC,
    OP_SMUL,
    OP_DINIT,
    OP_DSTEP,
    OP_SAT,
    OP_DIFF,
    OP_FSTEP,
    OP_FILT,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic waiting;
    logic sample_ok;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/spindle_follow_step_batcher_top.sv]
// a batch event steps through load, multiply, accumulate, position, error, batch,
// command, output; a resync through load, resync, output; a speed sample adds the
// multiply, init, bit-serial speed divider, saturate, difference and filter steps
// requests stall till idle; the next is taken while a result waits in its register
// reset (async, active low): positions, accumulator, speed filter cleared,
// direction clockwise, gear ratio 1.0, max batch 1024; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module spindle_follow_step_batcher_top #(
  parameter int ACC_FRAC_BITS = sfsb_pkg::ACC_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [0:0]                     action_i,
  input  logic signed [15:0]             encoder_delta_i,
  input  logic                           driver_stopped_i,
  input  logic [31:0]                    now_us_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    step_count_o,
  output logic                           move_cw_o,
  output logic                           waiting_reversal_o,
  output logic signed [31:0]             commanded_position_o,
  output logic signed [31:0]             spindle_pos_o,
  output logic signed [31:0]             target_speed_o
);
  import sfsb_pkg::*;

  op_e        op;
  dp_status_t status;

  // register writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  sfsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_action_i (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .op_o        (op)
  );

  sfsb_dpath #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .op_i                 (op),
    .status_o             (status),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .encoder_delta_i      (encoder_delta_i),
    .driver_stopped_i     (driver_stopped_i),
    .now_us_i             (now_us_i),
    .step_count_o         (step_count_o),
    .move_cw_o            (move_cw_o),
    .waiting_reversal_o   (waiting_reversal_o),
    .commanded_position_o (commanded_position_o),
    .spindle_pos_o        (spindle_pos_o),
    .target_speed_o       (target_speed_o)
  );

endmodule

`default_nettype wire

[rtl/sfsb_ctrl.sv]
// sequencer of the step batcher: walks one request through the datapath
// depends on sfsb_pkg; drives sfsb_dpath through op codes
`timescale 1ns / 1ps
`default_nettype none

module sfsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [0:0]          in_action_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sfsb_pkg::dp_status_t status_i,
  output sfsb_pkg::op_e        op_o
);
  import sfsb_pkg::*;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = (in_action_i == ACT_RESYNC) ? ST_RESYNC : ST_MUL;
        end
      end
      ST_MUL: begin
        op_o    = OP_MUL;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        op_o    = OP_ACC;
        state_d = ST_POS;
      end
      ST_POS: begin
        op_o    = OP_POS;
        state_d = ST_ERR;
      end
      ST_ERR: begin
        op_o    = OP_ERR;
        state_d = ST_BATCH;
      end
      ST_BATCH: begin
        op_o    = OP_BATCH;
        state_d = ST_CMD;
      end
      ST_CMD: begin
        op_o    = OP_CMD;
        state_d = (!status_i.waiting && status_i.sample_ok) ? ST_SMUL : ST_OUT;
      end
      ST_RESYNC: begin
        op_o    = OP_RESYNC;
        state_d = ST_OUT;
      end
      ST_SMUL: begin
        op_o    = OP_SMUL;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        op_o    = OP_DINIT;
        cnt_d   = DIV_CNT_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        op_o = OP_DSTEP;
        if (cnt_q == '0) begin
          state_d = ST_SAT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SAT: begin
        op_o    = OP_SAT;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        op_o    = OP_DIFF;
        state_d = ST_FSTEP;
      end
      ST_FSTEP: begin
        op_o    = OP_FSTEP;
        state_d = ST_FILT;
      end
      ST_FILT: begin
        op_o    = OP_FILT;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // result register free or being drained this cycle
        if (!out_valid_q || !out_stall_i) begin
          op_o        = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL || state_q == ST_RESYNC))
    else $error("accepted request did not start the sequence");

  a_valid_rises_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result shown outside the output step");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_SAT)
    else $error("divider did not finish after its last step");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_o && out_stall_i) |=> state_q == ST_OUT)
    else $error("held result overwritten");

endmodule

`default_nettype wire

[rtl/sfsb_dpath.sv]
// datapath of the step batcher: gear accumulator, batch decision,
// speed divider and filter, config and result registers; uses sfsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfsb_dpath #(
  parameter int ACC_FRAC_BITS = sfsb_pkg::ACC_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfsb_pkg::op_e                 op_i,
  output sfsb_pkg::dp_status_t          status_o,
  input  logic                          cfg_valid_i,
  input  logic [sfsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic signed [15:0]            encoder_delta_i,
  input  logic                          driver_stopped_i,
  input  logic [31:0]                   now_us_i,
  output logic [15:0]                   step_count_o,
  output logic                          move_cw_o,
  output logic                          waiting_reversal_o,
  output logic signed [31:0]            commanded_position_o,
  output logic signed [31:0]            spindle_pos_o,
  output logic signed [31:0]            target_speed_o
);
  import sfsb_pkg::*;

  localparam int AccW = 32 + ACC_FRAC_BITS;

  // config and persistent state
  logic [31:0]     gear_q;
  logic [15:0]     max_batch_q;
  logic [AccW-1:0] accum_q;
  logic [31:0]     target_q;
  logic [31:0]     commanded_q;
  logic            dir_q;
  logic [31:0]     last_time_q;
  logic [31:0]     last_target_q;
  logic [39:0]     filt_q;

  // per request working registers
  logic signed [15:0] enc_q;
  logic               stopped_q;
  logic [31:0]        now_q;
  logic signed [47:0] prod_q;
  logic [31:0]        err_q;
  logic [15:0]        steps_q;
  logic               waiting_q;
  logic [31:0]        dt_q;
  logic [31:0]        dpos_q;
  logic [59:0]        num_mag_q;
  logic               dpos_neg_q;
  logic [60:0]        num_q;
  logic [32:0]        den_q;
  logic [33:0]        rem_q;
  logic [60:0]        quo_q;
  logic [39:0]        inst_q;
  logic signed [46:0] diff51_q;
  logic [39:0]        step_q;

  // result register
  logic [15:0] res_steps_q;
  logic        res_cw_q;
  logic        res_wait_q;
  logic [31:0] res_cmd_q;
  logic [31:0] res_tgt_q;
  logic [31:0] res_spd_q;

  // product aligned to the accumulator fraction
  logic signed [63:0] prod_ext;
  logic [AccW-1:0]    prod_aligned;
  assign prod_ext = 64'(prod_q);

  if (ACC_FRAC_BITS >= 24) begin : g_align_up
    assign prod_aligned = AccW'(prod_ext <<< (ACC_FRAC_BITS - 24));
  end else begin : g_align_down
    localparam int Sh = 24 - ACC_FRAC_BITS;
    logic        prod_neg;
    logic [47:0] prod_mag;
    logic [47:0] prod_rnd;
    assign prod_neg     = prod_q[47];
    assign prod_mag     = prod_neg ? (48'd0 - prod_q) : prod_q;
    assign prod_rnd     = (prod_mag + (48'd1 << (Sh - 1))) >> Sh;
    assign prod_aligned = prod_neg ? AccW'(64'd0 - 64'(prod_rnd)) : AccW'(prod_rnd);
  end

  // accumulator rounded to whole steps, half away from zero
  logic            acc_neg;
  logic [AccW-1:0] acc_mag;
  logic [AccW-1:0] acc_rnd;
  logic [31:0]     pos_mag;
  logic [31:0]     target_d;
  assign acc_neg  = accum_q[AccW-1];
  assign acc_mag  = acc_neg ? (~accum_q + 1'b1) : accum_q;
  assign acc_rnd  = acc_mag + (AccW'(1) << (ACC_FRAC_BITS - 1));
  assign pos_mag  = acc_rnd[AccW-1:ACC_FRAC_BITS];
  assign target_d = acc_neg ? (32'd0 - pos_mag) : pos_mag;

  // batch decision
  logic        err_cw;
  logic        reversal;
  logic        waiting_d;
  logic [31:0] err_mag;
  logic [15:0] steps_d;
  assign err_cw    = !err_q[31];
  assign reversal  = (|err_q) && (err_cw != dir_q);
  assign waiting_d = reversal && !stopped_q;
  assign err_mag   = err_q[31] ? (32'd0 - err_q) : err_q;
  assign steps_d   = (err_mag > 32'(max_batch_q)) ? max_batch_q : err_mag[15:0];

  logic sample_ok;
  assign sample_ok = (dt_q >= 32'(MIN_SAMPLE_US));

  logic [31:0] dpos_abs;
  assign dpos_abs = dpos_q[31] ? (32'd0 - dpos_q) : dpos_q;

  // one restoring division step
  logic [33:0] rem_sh;
  logic [34:0] trial;
  assign rem_sh = {rem_q[32:0], num_q[60]};
  assign trial  = 35'(rem_sh) - 35'(den_q);

  // quotient clamped to the q.8 speed range
  logic        quo_big;
  logic [39:0] inst_d;
  assign quo_big = |quo_q[60:39];
  always_comb begin
    if (dpos_neg_q) begin
      inst_d = quo_big ? 40'h80_0000_0000 : (40'd0 - quo_q[39:0]);
    end else begin
      inst_d = quo_big ? 40'h7F_FFFF_FFFF : quo_q[39:0];
    end
  end

  logic signed [40:0] diff41;
  assign diff41 = $signed({inst_q[39], inst_q}) - $signed({filt_q[39], filt_q});

  // alpha step rounded half away from zero
  logic        s_neg;
  logic [46:0] s_mag;
  logic [46:0] s_rnd;
  assign s_neg = diff51_q[46];
  assign s_mag = s_neg ? (47'd0 - diff51_q) : diff51_q;
  assign s_rnd = (s_mag + 47'd128) >> 8;

  logic [40:0] sum41;
  logic [39:0] sum_sat;
  logic [39:0] filt_d;
  assign sum41   = {filt_q[39], filt_q} + {step_q[39], step_q};
  assign sum_sat = (sum41[40] != sum41[39]) ?
                   (sum41[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF) : sum41[39:0];
  // deadband below half a step per second
  assign filt_d  = (($signed(sum_sat) > -40'sd128) && ($signed(sum_sat) < 40'sd128)) ?
                   40'd0 : sum_sat;

  // filtered speed back to whole steps per second
  logic        f_neg;
  logic [39:0] f_mag;
  logic [39:0] f_rnd;
  logic [31:0] spd_d;
  assign f_neg = filt_q[39];
  assign f_mag = f_neg ? (40'd0 - filt_q) : filt_q;
  assign f_rnd = (f_mag + 40'd128) >> 8;
  always_comb begin
    if (!f_neg && f_rnd > 40'h00_7FFF_FFFF) begin
      spd_d = 32'h7FFF_FFFF;
    end else if (f_neg && f_rnd > 40'h00_8000_0000) begin
      spd_d = 32'h8000_0000;
    end else begin
      spd_d = f_neg ? (32'd0 - f_rnd[31:0]) : f_rnd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q        <= GEAR_RATIO_RESET;
      max_batch_q   <= MAX_BATCH_RESET;
      accum_q       <= '0;
      target_q      <= '0;
      commanded_q   <= '0;
      dir_q         <= 1'b1;
      last_time_q   <= '0;
      last_target_q <= '0;
      filt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GEAR_RATIO:      gear_q      <= cfg_data_i;
          CFG_MAX_BATCH_STEPS: max_batch_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (op_i)
        OP_ACC:    accum_q  <= accum_q + prod_aligned;
        OP_POS:    target_q <= target_d;
        OP_BATCH: begin
          if (reversal && stopped_q) begin
            dir_q <= err_cw;
          end
        end
        OP_CMD: begin
          if (!waiting_q) begin
            commanded_q <= dir_q ? (commanded_q + 32'(steps_q))
                                 : (commanded_q - 32'(steps_q));
            if (sample_ok) begin
              last_time_q   <= now_q;
              last_target_q <= target_q;
            end
          end
        end
        OP_RESYNC: commanded_q <= target_q;
        OP_FILT:   filt_q      <= filt_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        enc_q     <= encoder_delta_i;
        stopped_q <= driver_stopped_i;
        now_q     <= now_us_i;
      end
      OP_MUL: prod_q <= $signed(48'(enc_q)) * $signed({16'd0, gear_q});
      OP_ERR: err_q  <= target_q - commanded_q;
      OP_BATCH: begin
        steps_q   <= waiting_d ? 16'd0 : steps_d;
        waiting_q <= waiting_d;
        dt_q      <= now_q - last_time_q;
      end
      OP_CMD: dpos_q <= target_q - last_target_q;
      OP_RESYNC: begin
        steps_q   <= 16'd0;
        waiting_q <= 1'b0;
      end
      OP_SMUL: begin
        num_mag_q  <= 60'(dpos_abs) * 60'(SPEED_SCALE);
        dpos_neg_q <= dpos_q[31];
      end
      OP_DINIT: begin
        // (2*|num| + dt) / (2*dt) rounds half away from zero
        num_q <= {num_mag_q, 1'b0} + 61'(dt_q);
        den_q <= {dt_q, 1'b0};
        rem_q <= '0;
      end
      OP_DSTEP: begin
        num_q <= {num_q[59:0], 1'b0};
        if (!trial[34]) begin
          rem_q <= trial[33:0];
          quo_q <= {quo_q[59:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[59:0], 1'b0};
        end
      end
      OP_SAT:   inst_q   <= inst_d;
      OP_DIFF:  diff51_q <= $signed({{6{diff41[40]}}, diff41}) * 47'sd51;
      OP_FSTEP: step_q   <= s_neg ? 40'(47'd0 - s_rnd) : s_rnd[39:0];
      OP_OUT: begin
        res_steps_q <= steps_q;
        res_cw_q    <= dir_q;
        res_wait_q  <= waiting_q;
        res_cmd_q   <= commanded_q;
        res_tgt_q   <= target_q;
        res_spd_q   <= spd_d;
      end
      default: ;
    endcase
  end

  assign status_o.waiting   = waiting_q;
  assign status_o.sample_ok = sample_ok;

  assign step_count_o         = res_steps_q;
  assign move_cw_o            = res_cw_q;
  assign waiting_reversal_o   = res_wait_q;
  assign commanded_position_o = $signed(res_cmd_q);
  assign spindle_pos_o        = $signed(res_tgt_q);
  assign target_speed_o       = $signed(res_spd_q);

endmodule

`default_nettype wire
